>>> rtl/segment_hotness_classifier_assert.svh
// Assertion macros shared by the segment hotness classifier RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef SEGMENT_HOTNESS_CLASSIFIER_ASSERT_SVH
`define SEGMENT_HOTNESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define SHC_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("shc assertion failed");

// next-cycle implication
`define SHC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("shc assertion failed");

`endif

>>> rtl/shc_pkg.sv
// Package for the segment hotness classifier: constants, codes, control types.
// No dependencies.
`default_nettype none
package shc_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam logic [31:0] ONE_Q16       = 32'd65536;
    localparam logic [31:0] DECAY_SPAN    = 32'd43200;
    localparam logic [31:0] DECAY_SPAN_SQ = 32'd1866240000;
    localparam logic [31:0] GAIN_Q16      = 32'd655360;
    localparam logic [31:0] HOT_BOUND     = 32'd983040;
    localparam logic [31:0] HOTTEST_BOUND = 32'd1638400;

    localparam logic [1:0] CLS_COLD    = 2'd0;
    localparam logic [1:0] CLS_HOT     = 2'd1;
    localparam logic [1:0] CLS_HOTTEST = 2'd2;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_FIRST_TH    = 3'd1;
    localparam logic [2:0] REG_SECOND_TH   = 3'd2;
    localparam logic [2:0] REG_HOT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_HOTTEST_LIM = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV_START,
        ST_DIV,
        ST_RANK,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_lookup;
        logic scan_rank;
        logic mul1;
        logic mul2;
        logic div_start;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic decay_mode;
        logic need_rank;
    } sts_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] first_th;
        logic [15:0] second_th;
        logic [10:0] hot_limit;
        logic [10:0] hottest_limit;
    } cfg_t;

    function automatic logic [2:0] target_copies(input logic [1:0] cls);
        logic [2:0] t;
        case (cls)
            CLS_COLD:    t = 3'd0;
            CLS_HOT:     t = 3'd1;
            default:     t = 3'd3;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> rtl/shc_regs.sv
// APB-style configuration registers of the segment hotness classifier.
// Depends on shc_pkg.
`default_nettype none
module shc_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output shc_pkg::cfg_t     cfg
);
    import shc_pkg::*;

    cfg_t        cfg_reg;
    logic [2:0]  idx;
    logic        wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else if (wr_en) begin
            unique case (idx)
                REG_MODE:        cfg_reg.mode          <= pwdata[0];
                REG_FIRST_TH:    cfg_reg.first_th      <= pwdata[15:0];
                REG_SECOND_TH:   cfg_reg.second_th     <= pwdata[15:0];
                REG_HOT_LIMIT:   cfg_reg.hot_limit     <= pwdata[10:0];
                REG_HOTTEST_LIM: cfg_reg.hottest_limit <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:        prdata = {31'd0, cfg_reg.mode};
            REG_FIRST_TH:    prdata = {16'd0, cfg_reg.first_th};
            REG_SECOND_TH:   prdata = {16'd0, cfg_reg.second_th};
            REG_HOT_LIMIT:   prdata = {21'd0, cfg_reg.hot_limit};
            REG_HOTTEST_LIM: prdata = {21'd0, cfg_reg.hottest_limit};
            default:         prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/shc_div.sv
// Divider by the constant decay span squared: reciprocal multiply, back multiply and a
// remainder correction in registered steps, done raised with the quotient. Depends on shc_pkg.
// Quotient must fit 32 bits (dividend[62:32] < divisor).
`default_nettype none
module shc_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [62:0]  dividend,
    output logic              done,
    output logic [31:0]       quotient
);
    import shc_pkg::*;

    // floor(2^62 / divisor); estimate from the top 32 dividend bits runs low by at most 4
    localparam logic [31:0] RECIP   = 32'((64'd1 << 62) / 64'(DECAY_SPAN_SQ));
    localparam logic [33:0] SPAN_X1 = 34'(DECAY_SPAN_SQ);
    localparam logic [33:0] SPAN_X2 = 34'(64'(DECAY_SPAN_SQ) * 64'd2);
    localparam logic [33:0] SPAN_X3 = 34'(64'(DECAY_SPAN_SQ) * 64'd3);
    localparam logic [33:0] SPAN_X4 = 34'(64'(DECAY_SPAN_SQ) * 64'd4);

    logic        s1_reg, s2_reg, s3_reg;
    logic        done_reg;
    logic [62:0] x_reg;
    logic [31:0] est_reg;
    logic [62:0] back_reg;
    logic [31:0] quo_reg;
    logic [62:0] est_prod;
    logic [33:0] rem_c;
    logic [2:0]  adj_c;

    assign est_prod = 63'(64'(x_reg[62:31]) * 64'(RECIP));
    // remainder of the estimate is below five divisors
    assign rem_c    = 34'(x_reg - back_reg);

    always_comb begin
        if (rem_c >= SPAN_X4)      adj_c = 3'd4;
        else if (rem_c >= SPAN_X3) adj_c = 3'd3;
        else if (rem_c >= SPAN_X2) adj_c = 3'd2;
        else if (rem_c >= SPAN_X1) adj_c = 3'd1;
        else                       adj_c = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            s3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            done_reg <= s3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (start)
            x_reg <= dividend;
        if (s1_reg)
            est_reg <= est_prod[62:31];
        if (s2_reg)
            back_reg <= 63'(est_reg) * 63'(DECAY_SPAN_SQ);
        if (s3_reg)
            quo_reg <= est_reg + 32'(adj_c);
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> rtl/shc_ctrl.sv
// Controller state machine of the segment hotness classifier.
// Depends on shc_pkg and segment_hotness_classifier_assert.svh.
`default_nettype none
module shc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire shc_pkg::sts_t sts,
    output shc_pkg::cmd_t      cmd
);
    import shc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_LOOKUP;
            ST_LOOKUP:    if (sts.scan_done) state_next = ST_PREP;
            ST_PREP: begin
                if (sts.decay_mode)     state_next = ST_MUL1;
                else if (sts.need_rank) state_next = ST_RANK;
                else                    state_next = ST_COMMIT;
            end
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       if (sts.div_done) state_next = ST_COMMIT;
            ST_RANK:      if (sts.scan_done) state_next = ST_COMMIT;
            ST_COMMIT:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready        = 1'b1;
                cmd.capture     = in_valid;
                cmd.scan_lookup = in_valid;
            end
            ST_PREP:      cmd.scan_rank = !sts.decay_mode && sts.need_rank;
            ST_MUL1:      cmd.mul1 = 1'b1;
            ST_MUL2:      cmd.mul2 = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_COMMIT:    cmd.commit = out_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`include "segment_hotness_classifier_assert.svh"

    `SHC_ASSERT_NEXT(a_accept_starts_lookup, in_valid && in_ready, state_reg == ST_LOOKUP)
    `SHC_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_reg)
    `SHC_ASSERT_SAME(a_commit_no_overwrite, cmd.commit, !out_valid_reg || out_ready)
endmodule
`default_nettype wire

>>> rtl/shc_dp.sv
// Datapath of the segment hotness classifier: entry table, scan, decay and top-K math.
// Depends on shc_pkg and shc_div.
`default_nettype none
module shc_dp #(
    parameter int TABLE_DEPTH = shc_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire shc_pkg::cmd_t cmd,
    output shc_pkg::sts_t      sts,
    input  wire shc_pkg::cfg_t cfg,
    input  wire logic [63:0]   segment_id,
    input  wire logic [31:0]   current_time,
    input  wire logic [3:0]    cached_copies,
    output logic [1:0]         segment_class,
    output logic [31:0]        hotness_value,
    output logic [1:0]         copies_needed,
    output logic               table_full
);
    import shc_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // table memories
    logic [63:0] key_mem [TABLE_DEPTH];
    logic [31:0] hot_mem [TABLE_DEPTH];
    logic [31:0] stamp_mem [TABLE_DEPTH];
    logic [1:0]  cls_mem [TABLE_DEPTH];
    logic [63:0] rd_key_reg;
    logic [31:0] rd_hot_reg;
    logic [31:0] rd_stamp_reg;
    logic [1:0]  rd_cls_reg;

    logic [CNT_W-1:0] fill_reg;
    logic [63:0]      key_reg;
    logic [31:0]      now_reg;
    logic [3:0]       copies_reg;

    // scan
    logic             scan_active_reg;
    logic             scan_rank_reg;
    logic [CNT_W-1:0] addr_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             found_reg;
    logic [IDX_W-1:0] mslot_reg;
    logic [31:0]      oh_reg;
    logic [31:0]      ost_reg;
    logic [1:0]       ocls_reg;
    logic             match;
    logic             scan_done_c;
    logic             addr_in;

    // arithmetic
    logic [31:0] d_c;
    logic        big_reg;
    logic [31:0] dsq_reg;
    logic [30:0] f_c;
    logic [62:0] prod_reg;
    logic        div_done;
    logic [31:0] quo;
    logic [32:0] dsum;
    logic [31:0] dec_h;
    logic [1:0]  dec_cls;
    logic [32:0] ksum;
    logic [31:0] k_h;
    logic [1:0]  k_cls;
    logic        need_rank_c;
    logic [31:0] nh;
    logic [1:0]  ncls;
    logic        full_c;
    logic [IDX_W-1:0] slot_c;
    logic [2:0]  tgt;

    assign addr_in     = (addr_reg < fill_reg);
    assign match       = pend_reg && !scan_rank_reg && (rd_key_reg == key_reg);
    assign scan_done_c = scan_active_reg && (match || (!addr_in && !pend_reg));

    always_ff @(posedge clk) begin
        rd_key_reg   <= key_mem[addr_reg[IDX_W-1:0]];
        rd_hot_reg   <= hot_mem[addr_reg[IDX_W-1:0]];
        rd_stamp_reg <= stamp_mem[addr_reg[IDX_W-1:0]];
        rd_cls_reg   <= cls_mem[addr_reg[IDX_W-1:0]];
        if (cmd.commit && !full_c) begin
            key_mem[slot_c]   <= key_reg;
            hot_mem[slot_c]   <= nh;
            stamp_mem[slot_c] <= cfg.mode ? ost_reg : now_reg;
            cls_mem[slot_c]   <= ncls;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill_reg        <= '0;
            scan_active_reg <= 1'b0;
            scan_rank_reg   <= 1'b0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
        end
        else begin
            if (cmd.commit && !full_c && !found_reg)
                fill_reg <= fill_reg + CNT_W'(1);
            if (cmd.scan_lookup || cmd.scan_rank) begin
                scan_active_reg <= 1'b1;
                scan_rank_reg   <= cmd.scan_rank;
                addr_reg        <= '0;
                pend_reg        <= 1'b0;
            end
            else if (scan_active_reg) begin
                if (scan_done_c) begin
                    scan_active_reg <= 1'b0;
                    pend_reg        <= 1'b0;
                end
                else begin
                    pend_reg <= addr_in;
                    if (addr_in)
                        addr_reg <= addr_reg + CNT_W'(1);
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            key_reg    <= segment_id;
            now_reg    <= current_time;
            copies_reg <= cached_copies;
        end
        if (cmd.scan_lookup) begin
            found_reg <= 1'b0;
            oh_reg    <= '0;
            ost_reg   <= '0;
            ocls_reg  <= CLS_COLD;
        end
        if (cmd.scan_lookup || cmd.scan_rank)
            count_reg <= '0;
        if (scan_active_reg && !scan_done_c)
            pidx_reg <= addr_reg[IDX_W-1:0];
        if (match && scan_active_reg) begin
            found_reg <= 1'b1;
            mslot_reg <= pidx_reg;
            oh_reg    <= rd_hot_reg;
            ost_reg   <= rd_stamp_reg;
            ocls_reg  <= (rd_cls_reg > CLS_HOTTEST) ? CLS_HOTTEST : rd_cls_reg;
        end
        if (scan_active_reg && pend_reg && scan_rank_reg && (rd_hot_reg > k_h))
            count_reg <= count_reg + CNT_W'(1);
    end

    assign full_c = !found_reg && (fill_reg == DEPTH_C);
    assign slot_c = found_reg ? mslot_reg : fill_reg[IDX_W-1:0];

    // decay: h = old * (S^2 - d^2) / S^2 + gain, or gain alone when d > S
    assign d_c = now_reg - ost_reg;
    assign f_c = 31'(DECAY_SPAN_SQ - dsq_reg);

    always_ff @(posedge clk) begin
        if (cmd.mul1) begin
            big_reg <= (d_c > DECAY_SPAN);
            dsq_reg <= 32'(d_c[15:0]) * 32'(d_c[15:0]);
        end
        if (cmd.mul2)
            prod_reg <= 63'(oh_reg) * 63'(f_c);
    end

    shc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign dsum  = {1'b0, quo} + {1'b0, GAIN_Q16};
    assign dec_h = big_reg ? GAIN_Q16 : (dsum[32] ? 32'hFFFF_FFFF : dsum[31:0]);
    always_comb begin
        if (dec_h > HOTTEST_BOUND)  dec_cls = CLS_HOTTEST;
        else if (dec_h > HOT_BOUND) dec_cls = CLS_HOT;
        else                        dec_cls = CLS_COLD;
    end

    // top-K
    assign ksum = {1'b0, oh_reg} + {1'b0, ONE_Q16};
    assign k_h  = ksum[32] ? 32'hFFFF_FFFF : ksum[31:0];
    assign need_rank_c = !(k_h < {cfg.first_th, 16'd0}) &&
                         !((k_h < {cfg.second_th, 16'd0}) && (ocls_reg == CLS_HOT));

    always_comb begin
        if (!need_rank_c)
            k_cls = ocls_reg;
        else if (ocls_reg == CLS_COLD)
            k_cls = (32'(count_reg) < 32'(cfg.hot_limit)) ? CLS_HOT : CLS_COLD;
        else if (32'(count_reg) < 32'(cfg.hottest_limit))
            k_cls = CLS_HOTTEST;
        else if (32'(count_reg) >= 32'(cfg.hot_limit))
            k_cls = CLS_COLD;
        else
            k_cls = CLS_HOT;
    end

    assign nh   = cfg.mode ? k_h : dec_h;
    assign ncls = cfg.mode ? k_cls : dec_cls;
    assign tgt  = target_copies(ncls);

    always_ff @(posedge clk) begin
        if (cmd.commit) begin
            segment_class <= ncls;
            hotness_value <= nh;
            copies_needed <= ({1'b0, tgt} > copies_reg) ? 2'(tgt - copies_reg[2:0]) : 2'd0;
            table_full    <= full_c;
        end
    end

    assign sts.scan_done  = scan_done_c;
    assign sts.div_done   = div_done;
    assign sts.decay_mode = !cfg.mode;
    assign sts.need_rank  = need_rank_c;
endmodule
`default_nettype wire

>>> rtl/segment_hotness_classifier.sv
// One item at a time. Key lookup scans the N filled entries, one per cycle, stopping at a match.
// Decay mode then runs the multiply setup (PREP, MUL1, MUL2, DIV_START), the reciprocal divide
// and a commit; top-K mode goes straight to commit, or first runs a rank scan over the N entries
// when a reclass is due. Commit stalls while a result is held.
// Entries fill from slot 0 upward; reset clears fill count and control state, no table pass.
// Top level: instantiates shc_regs, shc_ctrl, shc_dp; depends on shc_pkg.
`default_nettype none
module segment_hotness_classifier #(
    parameter int TABLE_DEPTH = shc_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [63:0]  segment_id,
    input  wire logic [31:0]  current_time,
    input  wire logic [3:0]   cached_copies,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        segment_class,
    output logic [31:0]       hotness_value,
    output logic [1:0]        copies_needed,
    output logic              table_full
);
    import shc_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    shc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    shc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg),
        .segment_id    (segment_id),
        .current_time  (current_time),
        .cached_copies (cached_copies),
        .segment_class (segment_class),
        .hotness_value (hotness_value),
        .copies_needed (copies_needed),
        .table_full    (table_full)
    );
endmodule
`default_nettype wire
